FILE: hw/rtl/dual_hbridge_reversal_lockout_macros.svh
// Assertion macros used by dhrl_motor of the dual H-bridge drive.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef DUAL_HBRIDGE_REVERSAL_LOCKOUT_MACROS_SVH
`define DUAL_HBRIDGE_REVERSAL_LOCKOUT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHRL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("dhrl same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DHRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("dhrl next-cycle check failed");

`endif

FILE: hw/rtl/dhrl_pkg.sv
// Types, constants and the duty scaling function of the dual H-bridge drive.
// Has no dependencies; used by dhrl_motor and dual_hbridge_reversal_lockout.
package dhrl_pkg;

    localparam int DUTY_W = 7;
    localparam int CNT_W  = 16;
    localparam int SPEED_W = 8;

    localparam logic [CNT_W-1:0]          LOCKOUT_RESET = 16'd100;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX     = 8'sd100;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN     = -8'sd100;
    localparam logic [DUTY_W-1:0]         DUTY_OFFSET   = 7'd5;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_DRIVE  = 1'b1;
    localparam logic MOTOR_LEFT  = 1'b0;
    localparam logic MOTOR_RIGHT = 1'b1;

    typedef struct packed {
        logic                      func;
        logic                      motor_sel;
        logic signed [SPEED_W-1:0] speed_cmd;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_pos_duty;
        logic [DUTY_W-1:0] left_neg_duty;
        logic [DUTY_W-1:0] right_pos_duty;
        logic [DUTY_W-1:0] right_neg_duty;
        logic              applied;
    } out_item_t;

    typedef struct packed {
        logic                      tick;
        logic                      drive;
        logic signed [SPEED_W-1:0] speed;
    } motor_cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0] pos_duty;
        logic [DUTY_W-1:0] neg_duty;
        logic              applied;
    } motor_stat_t;

    // Duty is mag*95/100+5, i.e. floor(floor(mag*19/4)/5)+5.
    // The division by five uses 205/1024, exact for the values reached here.
    function automatic logic [DUTY_W-1:0] scale_duty(input logic [DUTY_W-1:0] mag);
        logic [11:0] prod19;
        logic [9:0]  quarter;
        logic [17:0] prod205;
        prod19  = 12'(mag) * 12'd19;
        quarter = prod19[11:2];
        prod205 = 18'(quarter) * 18'd205;
        return prod205[16:10] + DUTY_OFFSET;
    endfunction

endpackage

FILE: hw/rtl/dhrl_motor.sv
// One motor of the dual H-bridge drive: lockout counters, duty registers
// and the command decision. Depends on dhrl_pkg and the shared macro header.
`include "dual_hbridge_reversal_lockout_macros.svh"

module dhrl_motor
    import dhrl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  motor_cmd_t        cmd,
    input  logic [CNT_W-1:0]  lockout_count,
    output motor_stat_t       stat_next
);

    logic [CNT_W-1:0]  pos_cnt_reg, pos_cnt_next;
    logic [CNT_W-1:0]  neg_cnt_reg, neg_cnt_next;
    logic [DUTY_W-1:0] pos_duty_reg, pos_duty_next;
    logic [DUTY_W-1:0] neg_duty_reg, neg_duty_next;

    logic                in_range;
    logic                is_zero;
    logic                is_neg;
    logic [SPEED_W-1:0]  abs_speed;
    logic [DUTY_W-1:0]   scaled;
    logic                pos_ok;
    logic                neg_ok;
    logic                zero_ok;

    assign in_range  = (cmd.speed <= SPEED_MAX) && (cmd.speed >= SPEED_MIN);
    assign is_zero   = (cmd.speed == '0);
    assign is_neg    = cmd.speed[SPEED_W-1];
    assign abs_speed = is_neg ? (~cmd.speed + 8'd1) : cmd.speed;
    assign scaled    = scale_duty(abs_speed[DUTY_W-1:0]);

    assign zero_ok = cmd.drive && is_zero;
    assign pos_ok  = cmd.drive && in_range && !is_zero && !is_neg && (pos_cnt_reg == '0);
    assign neg_ok  = cmd.drive && in_range && is_neg && (neg_cnt_reg == '0);

    always_comb begin
        pos_cnt_next  = pos_cnt_reg;
        neg_cnt_next  = neg_cnt_reg;
        pos_duty_next = pos_duty_reg;
        neg_duty_next = neg_duty_reg;
        priority if (cmd.tick) begin
            if (pos_cnt_reg != '0) begin
                pos_cnt_next = pos_cnt_reg - 16'd1;
            end
            if (neg_cnt_reg != '0) begin
                neg_cnt_next = neg_cnt_reg - 16'd1;
            end
        end else if (zero_ok) begin
            pos_duty_next = '0;
            neg_duty_next = '0;
        end else if (pos_ok) begin
            neg_cnt_next  = lockout_count;
            neg_duty_next = '0;
            pos_duty_next = scaled;
        end else if (neg_ok) begin
            pos_cnt_next  = lockout_count;
            pos_duty_next = '0;
            neg_duty_next = scaled;
        end else begin
            pos_duty_next = pos_duty_reg;
        end
    end

    assign stat_next.pos_duty = pos_duty_next;
    assign stat_next.neg_duty = neg_duty_next;
    assign stat_next.applied  = zero_ok || pos_ok || neg_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_cnt_reg  <= LOCKOUT_RESET;
            neg_cnt_reg  <= LOCKOUT_RESET;
            pos_duty_reg <= '0;
            neg_duty_reg <= '0;
        end else if (en) begin
            pos_cnt_reg  <= pos_cnt_next;
            neg_cnt_reg  <= neg_cnt_next;
            pos_duty_reg <= pos_duty_next;
            neg_duty_reg <= neg_duty_next;
        end
    end

    `DHRL_ASSERT_SAME(a_one_direction, pos_duty_reg != '0, neg_duty_reg == '0)
    `DHRL_ASSERT_SAME(a_duty_range, 1'b1, (pos_duty_reg <= 7'd100) && (neg_duty_reg <= 7'd100))
    `DHRL_ASSERT_NEXT(a_pos_reload, en && pos_ok, neg_cnt_reg == $past(lockout_count))
    `DHRL_ASSERT_NEXT(a_neg_reload, en && neg_ok, pos_cnt_reg == $past(lockout_count))
    `DHRL_ASSERT_NEXT(a_tick_count, en && cmd.tick && (pos_cnt_reg != '0),
                      pos_cnt_reg == $past(pos_cnt_reg) - 16'd1)

endmodule

FILE: hw/rtl/dual_hbridge_reversal_lockout.sv
// Top level of the dual H-bridge drive with reversal lockout.
// Depends on dhrl_pkg and instantiates dhrl_motor twice.

// Each transaction on the s_ channel is a tick or a drive command and yields
// exactly one result transaction on the m_ channel carrying all four duties
// after it and the applied flag. An accepted transaction is held in the input
// register, decided by the per-motor logic while held there and captured in
// the result register when it advances, which waits while a result is offered
// and m_ready is low; one transaction per cycle is sustained while m_ready is
// high. The input register accepts while empty or handing its transaction
// on. The user is to write the lockout register through cfg_valid/cfg_data
// only while the block is idle; the block itself does not enforce this.
module dual_hbridge_reversal_lockout
    import dhrl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    logic             in_valid_reg;
    in_item_t         in_data_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg, out_data_next;
    logic [CNT_W-1:0] lockout_reg;
    logic             advance;

    motor_cmd_t  left_cmd, right_cmd;
    motor_stat_t left_stat, right_stat;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_comb begin
        left_cmd.tick   = (in_data_reg.func == FUNC_TICK);
        left_cmd.drive  = (in_data_reg.func == FUNC_DRIVE) &&
                          (in_data_reg.motor_sel == MOTOR_LEFT);
        left_cmd.speed  = in_data_reg.speed_cmd;
        right_cmd.tick  = (in_data_reg.func == FUNC_TICK);
        right_cmd.drive = (in_data_reg.func == FUNC_DRIVE) &&
                          (in_data_reg.motor_sel == MOTOR_RIGHT);
        right_cmd.speed = in_data_reg.speed_cmd;
    end

    dhrl_motor u_left (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .cmd           (left_cmd),
        .lockout_count (lockout_reg),
        .stat_next     (left_stat)
    );

    dhrl_motor u_right (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .cmd           (right_cmd),
        .lockout_count (lockout_reg),
        .stat_next     (right_stat)
    );

    always_comb begin
        out_data_next.left_pos_duty  = left_stat.pos_duty;
        out_data_next.left_neg_duty  = left_stat.neg_duty;
        out_data_next.right_pos_duty = right_stat.pos_duty;
        out_data_next.right_neg_duty = right_stat.neg_duty;
        out_data_next.applied        = left_stat.applied || right_stat.applied;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lockout_reg   <= LOCKOUT_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                lockout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
